FILE: rtl/signed_int_to_decimal_ascii_unit_defines.svh
// assertion macros shared by the signed integer to decimal text unit
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define SITDA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sitda assertion failed");

// condition must never be true out of reset
`define SITDA_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sitda forbidden condition seen");

`else

`define SITDA_ASSERT(label, clk, rst_n, prop)
`define SITDA_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/sitda_pkg.sv
// shared types and constants for the signed integer to decimal text unit
package sitda_pkg;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_CONVERT = 4'b0010,
        ST_SKIP    = 4'b0100,
        ST_EMIT    = 4'b1000
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic dabble;
        logic skip;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic bits_last;
        logic top_zero;
        logic one_left;
        logic neg;
    } t_status;

endpackage

FILE: rtl/sitda_dpath.sv
// datapath: magnitude, double-dabble bcd register, digit emission and output registers
`include "signed_int_to_decimal_ascii_unit_defines.svh"

module sitda_dpath
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic                   o_valid,
    output logic [7:0]             o_char_code,
    output logic                   o_last_char
);

    // decimal digits of 2^VALUE_WIDTH, enough for magnitudes up to 2^(VALUE_WIDTH-1)
    localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BW   = 4 * NDIG;
    localparam int BCW  = $clog2(VALUE_WIDTH + 1);
    localparam int DCW  = $clog2(NDIG + 1);

    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic [BW-1:0]          r_bcd, n_bcd;
    logic [BW-1:0]          bcd_adj;
    logic [BCW-1:0]         r_bit_cnt, n_bit_cnt;
    logic [DCW-1:0]         r_dig_left, n_dig_left;
    logic                   r_neg, n_neg;
    logic                   r_valid, n_valid;
    logic [7:0]             r_char, n_char;
    logic                   r_last, n_last;
    logic [3:0]             top_digit;
    logic [VALUE_WIDTH-1:0] neg_value;

    assign top_digit = r_bcd[BW-1 -: 4];
    assign neg_value = (~i_value) + VALUE_WIDTH'(1);

    // add-3 correction, one lane per bcd digit
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // status back to the controller
    assign o_status.bits_last = (r_bit_cnt == BCW'(1));
    assign o_status.top_zero  = (top_digit == 4'd0);
    assign o_status.one_left  = (r_dig_left == DCW'(1));
    assign o_status.neg       = r_neg;

    // next-state logic of the datapath
    always_comb begin
        n_mag      = r_mag;
        n_bcd      = r_bcd;
        n_bit_cnt  = r_bit_cnt;
        n_dig_left = r_dig_left;
        n_neg      = r_neg;
        n_valid    = 1'b0;
        n_char     = r_char;
        n_last     = r_last;
        if (i_cmd.load) begin
            // magnitude is exact even for the most negative value
            n_neg      = i_value[VALUE_WIDTH-1];
            n_mag      = i_value[VALUE_WIDTH-1] ? neg_value : i_value;
            n_bcd      = '0;
            n_bit_cnt  = BCW'(VALUE_WIDTH);
            n_dig_left = DCW'(NDIG);
        end
        if (i_cmd.dabble) begin
            n_bcd     = {bcd_adj[BW-2:0], r_mag[VALUE_WIDTH-1]};
            n_mag     = {r_mag[VALUE_WIDTH-2:0], 1'b0};
            n_bit_cnt = r_bit_cnt - BCW'(1);
        end
        if (i_cmd.skip) begin
            n_bcd      = {r_bcd[BW-5:0], 4'b0000};
            n_dig_left = r_dig_left - DCW'(1);
        end
        if (i_cmd.emit_sign) begin
            n_valid = 1'b1;
            n_char  = ASCII_MINUS;
            n_last  = 1'b0;
        end
        if (i_cmd.emit_digit) begin
            n_valid    = 1'b1;
            n_char     = ASCII_ZERO + {4'b0000, top_digit};
            n_last     = (r_dig_left == DCW'(1));
            n_bcd      = {r_bcd[BW-5:0], 4'b0000};
            n_dig_left = r_dig_left - DCW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_bit_cnt  <= '0;
            r_dig_left <= '0;
        end else begin
            r_valid    <= n_valid;
            r_bit_cnt  <= n_bit_cnt;
            r_dig_left <= n_dig_left;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    `SITDA_ASSERT(a_digit_in_range, i_clk, i_rst_n, i_cmd.emit_digit |-> top_digit <= 4'd9)
    `SITDA_NEVER(a_sign_not_last, i_clk, i_rst_n, r_valid && r_last && (r_char == ASCII_MINUS))
    `SITDA_NEVER(a_dabble_overrun, i_clk, i_rst_n, i_cmd.dabble && (r_bit_cnt == '0))

endmodule

FILE: rtl/sitda_ctrl.sv
// controller state machine: sequences load, conversion, zero skip and character transfers
`include "signed_int_to_decimal_ascii_unit_defines.svh"

module sitda_ctrl
    import sitda_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state, n_state;

    // state transitions and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                o_cmd.dabble = 1'b1;
                if (i_status.bits_last) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (i_status.top_zero && !i_status.one_left) begin
                    o_cmd.skip = 1'b1;
                end else begin
                    o_cmd.emit_sign = i_status.neg;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit_digit = 1'b1;
                if (i_status.one_left) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    `SITDA_ASSERT(a_start_enters_convert, i_clk, i_rst_n, (i_start && !o_busy) |=> (r_state == ST_CONVERT))
    `SITDA_ASSERT(a_cmd_exclusive, i_clk, i_rst_n, $onehot0(o_cmd))
    `SITDA_ASSERT(a_last_digit_frees, i_clk, i_rst_n, (o_cmd.emit_digit && i_status.one_left) |=> !o_busy)

endmodule

FILE: rtl/signed_int_to_decimal_ascii_unit.sv
// top level: signed integer to decimal ascii text converter
//
// Usage:
//   Drive i_value and raise start; the value is taken at the clock edge where
//   start is high and busy is low. busy stays high until the last character
//   of that value has been issued.
//   Characters come out most significant first on o_char_code, each valid for
//   exactly one cycle while o_valid is high; o_last_char marks the final one.
//   A negative value is led by '-', zero gives a single '0', and the most
//   negative value prints in full. Only the low VALUE_WIDTH bits are used.
// Timing:
//   VALUE_WIDTH double-dabble steps build the bcd digits, leading zero digits
//   are dropped one per cycle, any minus sign is issued on leaving the zero
//   skip, then one digit per cycle. A new value is not taken while busy is
//   high, as the bit-serial double-dabble loop and the digit-serial output
//   shift are in use; the next value is accepted in the cycle the last
//   character shows.
// Reset: i_rst_n is synchronous, active low, and returns the unit to idle
//   with no character pending. The receiver cannot stall the output.
module signed_int_to_decimal_ascii_unit
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    output logic [7:0]             o_char_code,
    output logic                   o_last_char
);

    t_cmd    cmd;
    t_status status;

    // sequencing
    sitda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // conversion and output registers
    sitda_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

FILE: tb/signed_int_to_decimal_ascii_unit_tb.sv
// testbench for the signed integer to decimal ascii text unit
module signed_int_to_decimal_ascii_unit_tb;
    import sitda_pkg::*;

    localparam int VALUE_WIDTH  = 32;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PRINT_CAP    = 20;

    // one character of decimal text
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [VALUE_WIDTH-1:0] i_value;
    logic                   o_valid;
    logic [7:0]             o_char_code;
    logic                   o_last_char;

    t_char pending_text[$];
    t_char want_char;
    int    mismatches;
    int    values_sent;
    int    negatives_sent;
    int    chars_checked;
    int    quiet_cycles;
    bit    idling_on;

    signed_int_to_decimal_ascii_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_char_code(o_char_code),
        .o_last_char(o_last_char)
    );

    // clock, period 2
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // print one mismatch line (up to a cap) and count it
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] wanted);
        if (mismatches < PRINT_CAP) begin
            $display("%0t mismatch: %s got %0d want %0d", $time, what, got, wanted);
        end
        mismatches++;
    endtask

    // expected text of one value: optional '-', then digits, msd first
    function automatic void predict_text(input logic [VALUE_WIDTH-1:0] value);
        logic                   negative;
        logic [VALUE_WIDTH:0]   magnitude;
        longint unsigned        remaining;
        logic [3:0]             digit_buf[0:19];
        int                     ndig;
        t_char                  ch;
        negative  = value[VALUE_WIDTH-1];
        // one bit wider so the most negative value does not wrap
        magnitude = negative ? ((VALUE_WIDTH+1)'(0) - {1'b1, value}) : {1'b0, value};
        remaining = 64'(magnitude);
        ndig      = 0;
        do begin
            digit_buf[ndig] = 4'(remaining % 10);
            remaining       = remaining / 10;
            ndig++;
        end while (remaining != 0);
        if (negative) begin
            ch.code = ASCII_MINUS;
            ch.last = 1'b0;
            pending_text.push_back(ch);
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            ch.code = ASCII_ZERO + 8'(digit_buf[k]);
            ch.last = (k == 0);
            pending_text.push_back(ch);
        end
    endfunction

    // random value spread over digit counts, signs and full bit patterns
    function automatic logic [VALUE_WIDTH-1:0] random_value();
        int                     mode;
        int                     nbits;
        logic [VALUE_WIDTH-1:0] mag;
        longint unsigned        pow10;
        mode = $urandom_range(0, 3);
        case (mode)
            0: begin
                return $urandom;
            end
            1: begin
                nbits = $urandom_range(1, VALUE_WIDTH - 1);
                mag   = $urandom & ((32'd1 << nbits) - 32'd1);
            end
            2: begin
                mag = $urandom_range(0, 20);
            end
            default: begin
                pow10 = 1;
                repeat ($urandom_range(1, 9)) pow10 = pow10 * 10;
                mag = 32'(pow10) + 32'($urandom_range(0, 2)) - 32'd1;
            end
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // one transfer, then an optional idle burst
    task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
        int gap;
        i_value <= value;
        start   <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_text(value);
        values_sent++;
        if (value[VALUE_WIDTH-1]) negatives_sent++;
        if (idling_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // zero and single digit values of both signs
    task automatic test_zero_and_sign();
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(5);
        send_value(-7);
    endtask

    // ends of the range and alternating bit patterns
    task automatic test_range_ends();
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h8000_0001);
        send_value(32'hFFFF_FFFE);
        send_value(32'hAAAA_AAAA);
        send_value(32'h5555_5555);
    endtask

    // changes in digit count, where leading zero suppression matters
    task automatic test_digit_boundaries();
        send_value(9);
        send_value(10);
        send_value(-9);
        send_value(-10);
        send_value(99999);
        send_value(100000);
        send_value(999999999);
        send_value(1000000000);
        send_value(-999999999);
        send_value(-1000000000);
    endtask

    // random values with idle bursts on the input side
    task automatic test_random_values(input int count);
        idling_on = 1'b1;
        repeat (count) send_value(random_value());
    endtask

    // random values sent back to back with no idling
    task automatic test_back_to_back(input int count);
        idling_on = 1'b0;
        repeat (count) send_value(random_value());
    endtask

    // check every character against the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_text.size() == 0) begin
                report_mismatch("character with nothing pending", o_char_code, 8'd0);
            end else begin
                want_char = pending_text.pop_front();
                if (o_char_code !== want_char.code)
                    report_mismatch("char_code", o_char_code, want_char.code);
                if (o_last_char !== want_char.last)
                    report_mismatch("last_char", 8'(o_last_char), 8'(want_char.last));
                chars_checked++;
            end
        end
    end

    // watchdog: too many cycles with no transfer on either side
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) || o_valid === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // main sequence
    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_value        = '0;
        idling_on      = 1'b0;
        mismatches     = 0;
        values_sent    = 0;
        negatives_sent = 0;
        chars_checked  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_and_sign();
        test_range_ends();
        test_digit_boundaries();
        test_random_values(130);
        test_back_to_back(30);
        start <= 1'b0;

        // drain the outstanding text, then watch for stray characters
        while (pending_text.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d values (%0d negative), %0d characters checked",
                 values_sent, negatives_sent, chars_checked);
        $display("covered zero, range ends, digit count changes, random and back to back");
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sitda_pkg.sv
rtl/sitda_dpath.sv
rtl/sitda_ctrl.sv
rtl/signed_int_to_decimal_ascii_unit.sv
tb/signed_int_to_decimal_ascii_unit_tb.sv
